// ===== sv/sdspi_pkg.sv =====
// ----------------------------------------------------------------------------
// SD SPI engine package
// Shared types and constants for the SD card SPI command and init engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sdspi_pkg;

  // Response polling and op-cond retry limits
  localparam int POLL_LIMIT         = 256;
  localparam int OPCOND_RETRY_LIMIT = 4095;

  localparam int POLL_W  = $clog2(POLL_LIMIT + 1);
  localparam int RETRY_W = 12;
  localparam int BCNT_W  = 4;

  // Item command codes
  localparam logic [1:0] CODE_ISSUE = 2'd0;
  localparam logic [1:0] CODE_INIT  = 2'd1;
  localparam logic [1:0] CODE_RX    = 2'd2;

  // Byte counts of the bus phases
  localparam logic [BCNT_W-1:0] CMD_BYTES   = 4'd6;
  localparam logic [BCNT_W-1:0] OCR_BYTES   = 4'd4;
  localparam logic [BCNT_W-1:0] DUMMY_BYTES = 4'd10;
  localparam logic [BCNT_W-1:0] GAP_BYTES   = 4'd2;

  // Bytes on the bus
  localparam logic [7:0] IDLE_BYTE = 8'hFF;
  localparam logic [7:0] CRC_CMD8  = 8'h87;
  localparam logic [7:0] CRC_OTHER = 8'h95;
  localparam logic [7:0] R1_IDLE   = 8'h01;
  localparam logic [7:0] R1_READY  = 8'h00;

  // SD command numbers
  localparam logic [5:0] SD_CMD0  = 6'd0;
  localparam logic [5:0] SD_CMD8  = 6'd8;
  localparam logic [5:0] SD_CMD17 = 6'd17;
  localparam logic [5:0] SD_CMD24 = 6'd24;
  localparam logic [5:0] SD_CMD41 = 6'd41;
  localparam logic [5:0] SD_CMD55 = 6'd55;
  localparam logic [5:0] SD_CMD58 = 6'd58;

  localparam logic [31:0] ARG_CMD8  = 32'h0000_01AA;
  localparam logic [31:0] ARG_CMD41 = 32'h4000_0000;

  // Retry thresholds
  localparam logic [RETRY_W-1:0] CMD0_RETRY_MAX = 12'h020;
  localparam logic [RETRY_W-1:0] CMD8_RETRY_MAX = 12'h0FE;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TX,
    PH_POLL,
    PH_OCR,
    PH_TAIL,
    PH_DUMMY,
    PH_GAP
  } phase_t;

  typedef enum logic [2:0] {
    ST_NONE,
    ST_CMD0,
    ST_CMD8,
    ST_CMD55,
    ST_CMD41,
    ST_CMD58
  } stage_t;

endpackage

`default_nettype wire

// ===== sv/sd_spi_command_and_init_engine.sv =====
// ----------------------------------------------------------------------------
// SD SPI command and init engine
// Byte-level SD card SPI-mode command sequencer and card initialization.
// ----------------------------------------------------------------------------
// Usage: each item is handled in the cycle it is accepted, so the engine takes
// one item per clock unless stalled. Send command 0 (issue cmd_index with
// argument) or command 1 (run card init) while idle; the engine answers with
// a byte request (tx_valid, tx_byte, chip_select). Exchange that byte on the
// bus and return what the card shifted back as a command 2 item; repeat until
// a result with done_res arrives, carrying the R1 response (0xFF on poll
// timeout) and, for init, init_failed. Requests while busy, bytes while idle
// and the unused code 3 are absorbed without a result. The result sits in a
// one-entry output register; in_ready drops only while that register holds a
// result that the sink has not taken, so the sustained rate is one item per
// cycle only while the sink keeps taking results.
`default_nettype none

module sd_spi_command_and_init_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [5:0]  cmd_index,
  input  logic [31:0] argument,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        chip_select,
  output logic        done_res,
  output logic [7:0]  response,
  output logic        init_failed,
  output logic        high_capacity
);

  import sdspi_pkg::*;

  // Engine state
  phase_t               phase, phase_next;
  stage_t               stage, stage_next;
  logic [BCNT_W-1:0]    byte_cnt, byte_cnt_next;
  logic [POLL_W-1:0]    poll_cnt, poll_cnt_next;
  logic [RETRY_W-1:0]   retry_cnt, retry_cnt_next;
  logic                 card_hc, card_hc_next;
  logic                 card_v1, card_v1_next;
  logic [5:0]           held_cmd, held_cmd_next;
  logic [31:0]          held_arg, held_arg_next;
  logic [7:0]           held_resp, held_resp_next;

  // Per-item decode
  logic                 accept;
  logic                 res_valid;
  logic                 res_done;
  logic                 res_fail;
  logic                 start_req;
  logic [5:0]           start_cmd;
  logic [31:0]          start_arg;
  logic                 fin_req;
  logic [RETRY_W:0]     retry_inc;
  logic [7:0]           pend_byte;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign retry_inc = {1'b0, retry_cnt} + {{RETRY_W{1'b0}}, 1'b1};

  always_comb begin
    phase_next     = phase;
    stage_next     = stage;
    byte_cnt_next  = byte_cnt;
    poll_cnt_next  = poll_cnt;
    retry_cnt_next = retry_cnt;
    card_hc_next   = card_hc;
    card_v1_next   = card_v1;
    held_cmd_next  = held_cmd;
    held_arg_next  = held_arg;
    held_resp_next = held_resp;
    res_valid      = 1'b0;
    res_fail       = 1'b0;
    start_req      = 1'b0;
    start_cmd      = SD_CMD0;
    start_arg      = '0;
    fin_req        = 1'b0;

    case (command)
      CODE_RX: begin
        if (phase != PH_IDLE) begin
          res_valid = 1'b1;
          unique case (phase)
            PH_TX: begin
              byte_cnt_next = byte_cnt + 1'b1;
              if (byte_cnt_next >= CMD_BYTES) begin
                phase_next    = PH_POLL;
                poll_cnt_next = '0;
              end
            end
            PH_POLL: begin
              // Poll R1 until the card drives a non-idle byte or time runs out
              poll_cnt_next = poll_cnt + 1'b1;
              if (rx_byte != IDLE_BYTE || poll_cnt_next >= POLL_W'(POLL_LIMIT)) begin
                held_resp_next = (rx_byte != IDLE_BYTE) ? rx_byte : IDLE_BYTE;
                byte_cnt_next  = '0;
                phase_next = (held_resp_next == R1_READY && held_cmd == SD_CMD58) ?
                             PH_OCR : PH_TAIL;
              end
            end
            PH_OCR: begin
              if (byte_cnt == '0) begin
                card_hc_next = rx_byte[6];
              end
              byte_cnt_next = byte_cnt + 1'b1;
              if (byte_cnt_next >= OCR_BYTES) begin
                phase_next = PH_TAIL;
              end
            end
            PH_TAIL: begin
              unique case (stage)
                ST_NONE: begin
                  fin_req = 1'b1;
                end
                ST_CMD0: begin
                  if (held_resp == R1_IDLE) begin
                    phase_next    = PH_GAP;
                    byte_cnt_next = '0;
                  end else if (retry_cnt > CMD0_RETRY_MAX) begin
                    fin_req  = 1'b1;
                    res_fail = 1'b1;
                  end else begin
                    retry_cnt_next = retry_inc[RETRY_W-1:0];
                    start_req      = 1'b1;
                    start_cmd      = SD_CMD0;
                  end
                end
                ST_CMD8: begin
                  if (held_resp != R1_IDLE && retry_cnt <= CMD8_RETRY_MAX) begin
                    retry_cnt_next = retry_inc[RETRY_W-1:0];
                    start_req      = 1'b1;
                    start_cmd      = SD_CMD8;
                    start_arg      = ARG_CMD8;
                  end else begin
                    // No answer to CMD8: treat as a version one card
                    if (held_resp != R1_IDLE) begin
                      card_v1_next = 1'b1;
                    end
                    retry_cnt_next = '0;
                    stage_next     = ST_CMD55;
                    start_req      = 1'b1;
                    start_cmd      = SD_CMD55;
                  end
                end
                ST_CMD55: begin
                  stage_next = ST_CMD41;
                  start_req  = 1'b1;
                  start_cmd  = SD_CMD41;
                  start_arg  = ARG_CMD41;
                end
                ST_CMD41: begin
                  retry_cnt_next = retry_inc[RETRY_W-1:0];
                  if (retry_inc >= (RETRY_W+1)'(OPCOND_RETRY_LIMIT)) begin
                    fin_req  = 1'b1;
                    res_fail = 1'b1;
                  end else if (held_resp == R1_READY) begin
                    retry_cnt_next = '0;
                    card_hc_next   = 1'b0;
                    if (card_v1) begin
                      fin_req = 1'b1;
                    end else begin
                      stage_next = ST_CMD58;
                      start_req  = 1'b1;
                      start_cmd  = SD_CMD58;
                    end
                  end else begin
                    stage_next = ST_CMD55;
                    start_req  = 1'b1;
                    start_cmd  = SD_CMD55;
                  end
                end
                default: begin
                  // CMD58: the card answers ready, or give up and keep going
                  if (held_resp == R1_READY || retry_cnt > CMD8_RETRY_MAX) begin
                    fin_req = 1'b1;
                  end else begin
                    retry_cnt_next = retry_inc[RETRY_W-1:0];
                    start_req      = 1'b1;
                    start_cmd      = SD_CMD58;
                  end
                end
              endcase
            end
            PH_DUMMY: begin
              byte_cnt_next = byte_cnt + 1'b1;
              if (byte_cnt_next >= DUMMY_BYTES) begin
                stage_next     = ST_CMD0;
                retry_cnt_next = '0;
                start_req      = 1'b1;
                start_cmd      = SD_CMD0;
              end
            end
            PH_GAP: begin
              byte_cnt_next = byte_cnt + 1'b1;
              if (byte_cnt_next >= GAP_BYTES) begin
                stage_next     = ST_CMD8;
                retry_cnt_next = '0;
                start_req      = 1'b1;
                start_cmd      = SD_CMD8;
                start_arg      = ARG_CMD8;
              end
            end
            default: begin
              res_valid = 1'b0;
            end
          endcase
        end
      end
      CODE_ISSUE: begin
        if (phase == PH_IDLE) begin
          res_valid  = 1'b1;
          stage_next = ST_NONE;
          start_req  = 1'b1;
          start_cmd  = cmd_index;
          start_arg  = argument;
        end
      end
      CODE_INIT: begin
        if (phase == PH_IDLE) begin
          res_valid      = 1'b1;
          card_v1_next   = 1'b0;
          stage_next     = ST_NONE;
          retry_cnt_next = '0;
          byte_cnt_next  = '0;
          phase_next     = PH_DUMMY;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase

    // Launch a command: block addresses become byte addresses on SDSC cards
    if (start_req) begin
      held_cmd_next = start_cmd;
      held_arg_next = start_arg;
      if (!card_hc_next && (start_cmd == SD_CMD17 || start_cmd == SD_CMD24)) begin
        held_arg_next = {start_arg[22:0], 9'd0};
      end
      byte_cnt_next = '0;
      poll_cnt_next = '0;
      phase_next    = PH_TX;
    end

    if (fin_req) begin
      stage_next = ST_NONE;
      phase_next = PH_IDLE;
    end
  end

  assign res_done = fin_req;

  // Next byte on the bus, from the state the item leaves behind
  always_comb begin
    pend_byte = IDLE_BYTE;
    if (phase_next == PH_TX) begin
      case (byte_cnt_next)
        4'd0:    pend_byte = {2'b01, held_cmd_next};
        4'd1:    pend_byte = held_arg_next[31:24];
        4'd2:    pend_byte = held_arg_next[23:16];
        4'd3:    pend_byte = held_arg_next[15:8];
        4'd4:    pend_byte = held_arg_next[7:0];
        default: pend_byte = (held_cmd_next == SD_CMD8) ? CRC_CMD8 : CRC_OTHER;
      endcase
    end
  end

  // State register: advance only on an accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      stage     <= ST_NONE;
      byte_cnt  <= '0;
      poll_cnt  <= '0;
      retry_cnt <= '0;
      card_hc   <= 1'b0;
      card_v1   <= 1'b0;
      held_cmd  <= '0;
      held_arg  <= '0;
      held_resp <= IDLE_BYTE;
    end else if (accept) begin
      phase     <= phase_next;
      stage     <= stage_next;
      byte_cnt  <= byte_cnt_next;
      poll_cnt  <= poll_cnt_next;
      retry_cnt <= retry_cnt_next;
      card_hc   <= card_hc_next;
      card_v1   <= card_v1_next;
      held_cmd  <= held_cmd_next;
      held_arg  <= held_arg_next;
      held_resp <= held_resp_next;
    end
  end

  // Result register: hold until taken, drop when the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      tx_valid      <= !res_done;
      tx_byte       <= res_done ? 8'h00 : pend_byte;
      chip_select   <= !res_done && !(phase_next == PH_DUMMY || phase_next == PH_GAP);
      done_res      <= res_done;
      response      <= res_done ? held_resp_next : 8'h00;
      init_failed   <= res_fail;
      high_capacity <= card_hc_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sdspi_checker.sv =====
// ----------------------------------------------------------------------------
// SD SPI engine checker
// Port-level temporal checks for the SD SPI command and init engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sdspi_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_ready,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       tx_valid,
  input  logic [7:0] tx_byte,
  input  logic       done_res,
  input  logic [7:0] response,
  input  logic       init_failed
);

  // A stalled result holds its content
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(tx_byte) && $stable(response)))
    else $error("stalled result changed");

  // An empty result register never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A result is either a byte request or a completion, never both
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tx_valid != done_res))
    else $error("result is neither or both byte request and completion");

  // Byte requests carry no response and no failure
  a_req: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tx_valid) |-> (response == 8'h00 && !init_failed))
    else $error("byte request carries completion fields");

endmodule

bind sd_spi_command_and_init_engine sdspi_checker u_sdspi_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .tx_valid    (tx_valid),
  .tx_byte     (tx_byte),
  .done_res    (done_res),
  .response    (response),
  .init_failed (init_failed)
);

`default_nettype wire
